// ===== hw/rtl/jpeg_marker_segment_parser_macros.svh =====
// Assertion macros for the JPEG marker segment parser.
// Used by the top level only; needs clock and reset in the scope of use.
`ifndef JPEG_MARKER_SEGMENT_PARSER_MACROS_SVH
`define JPEG_MARKER_SEGMENT_PARSER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define JMSP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define JMSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/jmsp_pkg.sv =====
// Package for the JPEG marker segment parser: phase type, event codes,
// parser state and event structs. Depends on nothing.
`timescale 1ns / 1ps

package jmsp_pkg;

   typedef enum logic [3:0] {
      PH_SCAN    = 4'd0,
      PH_FF      = 4'd1,
      PH_APP0    = 4'd2,
      PH_APPN    = 4'd3,
      PH_DQT     = 4'd4,
      PH_SOF0    = 4'd5,
      PH_DRI     = 4'd6,
      PH_DHT     = 4'd7,
      PH_SOS     = 4'd8,
      PH_ENTROPY = 4'd9
   } phase_type;

   localparam logic [4:0] K_MARKER    = 5'd0;
   localparam logic [4:0] K_LENGTH    = 5'd1;
   localparam logic [4:0] K_APP0_ID   = 5'd2;
   localparam logic [4:0] K_APP0_VER  = 5'd3;
   localparam logic [4:0] K_APP0_UNIT = 5'd4;
   localparam logic [4:0] K_APP0_XD   = 5'd5;
   localparam logic [4:0] K_APP0_YD   = 5'd6;
   localparam logic [4:0] K_APP0_TW   = 5'd7;
   localparam logic [4:0] K_APP0_TH   = 5'd8;
   localparam logic [4:0] K_APP0_TB   = 5'd9;
   localparam logic [4:0] K_DQT_HDR   = 5'd10;
   localparam logic [4:0] K_DQT_BYTE  = 5'd11;
   localparam logic [4:0] K_SOF_PREC  = 5'd12;
   localparam logic [4:0] K_SOF_H     = 5'd13;
   localparam logic [4:0] K_SOF_W     = 5'd14;
   localparam logic [4:0] K_SOF_NC    = 5'd15;
   localparam logic [4:0] K_SOF_CID   = 5'd16;
   localparam logic [4:0] K_SOF_SAMP  = 5'd17;
   localparam logic [4:0] K_SOF_QT    = 5'd18;
   localparam logic [4:0] K_DRI       = 5'd19;
   localparam logic [4:0] K_DHT_BYTE  = 5'd20;
   localparam logic [4:0] K_SOS_NC    = 5'd21;
   localparam logic [4:0] K_SOS_CID   = 5'd22;
   localparam logic [4:0] K_SOS_TBL   = 5'd23;
   localparam logic [4:0] K_SOS_SS    = 5'd24;
   localparam logic [4:0] K_SOS_SE    = 5'd25;
   localparam logic [4:0] K_SOS_AH    = 5'd26;
   localparam logic [4:0] K_ENTROPY   = 5'd27;

   localparam logic [7:0] MK_SOI   = 8'hD8;
   localparam logic [7:0] MK_EOI   = 8'hD9;
   localparam logic [7:0] MK_APP0  = 8'hE0;
   localparam logic [7:0] MK_APP1  = 8'hE1;
   localparam logic [7:0] MK_APP15 = 8'hEF;
   localparam logic [7:0] MK_DQT   = 8'hDB;
   localparam logic [7:0] MK_SOF0  = 8'hC0;
   localparam logic [7:0] MK_DRI   = 8'hDD;
   localparam logic [7:0] MK_DHT   = 8'hC4;
   localparam logic [7:0] MK_SOS   = 8'hDA;
   localparam logic [7:0] MK_FILL  = 8'hFF;

   localparam logic [7:0] QT_SHORT = 8'd64;
   localparam logic [7:0] QT_LONG  = 8'd128;
   localparam logic [15:0] THUMB_BASE = 16'd16;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] cnt;
      logic [15:0] seg_len;
      logic [7:0]  hold;
      logic [7:0]  comp_total;
      logic [7:0]  comp_idx;
      logic [1:0]  sub;
      logic [7:0]  qt_slot;
      logic [7:0]  qt_rem;
      logic [7:0]  dly0;
      logic [7:0]  dly1;
      logic [1:0]  fill;
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [4:0]  kind;
      logic [7:0]  slot;
      logic [15:0] value;
      logic [7:0]  value_second;
   } event_type;

endpackage

// ===== hw/rtl/jmsp_step.sv =====
// Next-state and event logic for one file byte of the marker parser.
// Purely combinational; depends on jmsp_pkg.
`timescale 1ns / 1ps

module jmsp_step
   import jmsp_pkg::*;
(
   input  state_type  cur,
   input  logic [7:0] data_byte,
   output state_type  nxt,
   output event_type  evt
);

   logic [15:0] c;
   logic [15:0] word;
   logic [15:0] len_now;
   logic [15:0] b16;
   logic [16:0] c_plus;

   assign c    = cur.cnt;
   assign word = {cur.hold, data_byte};
   assign b16  = {8'd0, data_byte};
   assign len_now = (c == 16'd1) ? word : cur.seg_len;
   assign c_plus  = {1'b0, c} + 17'd1;

   always_comb begin
      nxt = cur;
      evt = '0;
      unique case (cur.phase)
         PH_SCAN: begin
            if (data_byte == MK_FILL) begin
               nxt.phase = PH_FF;
            end
         end
         PH_FF: begin
            if (data_byte != MK_FILL) begin
               evt.valid = 1'b1;
               evt.kind  = K_MARKER;
               evt.value = b16;
               nxt.cnt = '0;
               nxt.seg_len = '0;
               nxt.comp_total = '0;
               nxt.comp_idx = '0;
               nxt.sub = '0;
               nxt.qt_slot = '0;
               nxt.qt_rem = '0;
               if (data_byte == MK_SOI || data_byte == MK_EOI) begin
                  nxt = cur;
                  nxt.phase = PH_SCAN;
               end else if (data_byte == MK_APP0) begin
                  nxt.phase = PH_APP0;
               end else if (data_byte >= MK_APP1 && data_byte <= MK_APP15) begin
                  nxt.phase = PH_APPN;
               end else if (data_byte == MK_DQT) begin
                  nxt.phase = PH_DQT;
               end else if (data_byte == MK_SOF0) begin
                  nxt.phase = PH_SOF0;
               end else if (data_byte == MK_DRI) begin
                  nxt.phase = PH_DRI;
               end else if (data_byte == MK_DHT) begin
                  nxt.phase = PH_DHT;
               end else if (data_byte == MK_SOS) begin
                  nxt.phase = PH_SOS;
               end else begin
                  nxt = cur;
                  nxt.phase = PH_SCAN;
                  evt.valid = 1'b0;
               end
            end
         end
         PH_ENTROPY: begin
            if (cur.fill == 2'd2) begin
               evt.valid = 1'b1;
               evt.kind  = K_ENTROPY;
               evt.slot  = c[7:0];
               evt.value = {8'd0, cur.dly0};
               nxt.cnt   = c_plus[15:0];
               nxt.dly0  = cur.dly1;
               nxt.dly1  = data_byte;
            end else if (cur.fill == 2'd1) begin
               nxt.dly1 = data_byte;
               nxt.fill = 2'd2;
            end else begin
               nxt.dly0 = data_byte;
               nxt.fill = 2'd1;
            end
         end
         PH_APP0, PH_APPN, PH_DQT, PH_SOF0, PH_DRI, PH_DHT, PH_SOS: begin
            if (c == 16'd0) begin
               nxt.hold = data_byte;
            end else if (c == 16'd1) begin
               nxt.seg_len = word;
               evt.valid = 1'b1;
               evt.kind  = K_LENGTH;
               evt.value = word;
            end else begin
               unique case (cur.phase)
                  PH_APP0: begin
                     evt.valid = 1'b1;
                     evt.value = b16;
                     if (c <= 16'd6) begin
                        evt.kind = K_APP0_ID;
                        evt.slot = c[7:0] - 8'd2;
                     end else if (c == 16'd7 || c == 16'd10 || c == 16'd12) begin
                        nxt.hold = data_byte;
                        evt.valid = 1'b0;
                     end else if (c == 16'd8) begin
                        evt.kind = K_APP0_VER;
                        evt.value = {8'd0, cur.hold};
                        evt.value_second = data_byte;
                     end else if (c == 16'd9) begin
                        evt.kind = K_APP0_UNIT;
                     end else if (c == 16'd11) begin
                        evt.kind = K_APP0_XD;
                        evt.value = word;
                     end else if (c == 16'd13) begin
                        evt.kind = K_APP0_YD;
                        evt.value = word;
                     end else if (c == 16'd14) begin
                        evt.kind = K_APP0_TW;
                     end else if (c == 16'd15) begin
                        evt.kind = K_APP0_TH;
                     end else begin
                        evt.kind = K_APP0_TB;
                        evt.slot = c[7:0] - THUMB_BASE[7:0];
                     end
                  end
                  PH_DQT: begin
                     evt.valid = 1'b1;
                     if (cur.qt_rem == 8'd0) begin
                        evt.kind = K_DQT_HDR;
                        evt.slot = cur.qt_slot;
                        evt.value = {12'd0, data_byte[7:4]};
                        evt.value_second = {4'd0, data_byte[3:0]};
                        nxt.qt_rem = (data_byte[7:4] != 4'd0) ? QT_LONG : QT_SHORT;
                        nxt.comp_idx = '0;
                        nxt.qt_slot = cur.qt_slot + 8'd1;
                     end else begin
                        evt.kind = K_DQT_BYTE;
                        evt.slot = cur.comp_idx;
                        evt.value = b16;
                        nxt.qt_rem = cur.qt_rem - 8'd1;
                        nxt.comp_idx = cur.comp_idx + 8'd1;
                     end
                  end
                  PH_SOF0: begin
                     evt.value = b16;
                     if (c == 16'd2) begin
                        evt.valid = 1'b1;
                        evt.kind = K_SOF_PREC;
                     end else if (c == 16'd3 || c == 16'd5) begin
                        nxt.hold = data_byte;
                     end else if (c == 16'd4) begin
                        evt.valid = 1'b1;
                        evt.kind = K_SOF_H;
                        evt.value = word;
                     end else if (c == 16'd6) begin
                        evt.valid = 1'b1;
                        evt.kind = K_SOF_W;
                        evt.value = word;
                     end else if (c == 16'd7) begin
                        evt.valid = 1'b1;
                        evt.kind = K_SOF_NC;
                        nxt.comp_total = data_byte;
                        nxt.comp_idx = '0;
                        nxt.sub = '0;
                     end else if (cur.comp_idx < cur.comp_total) begin
                        evt.valid = 1'b1;
                        evt.slot = cur.comp_idx;
                        if (cur.sub == 2'd0) begin
                           evt.kind = K_SOF_CID;
                           nxt.sub = 2'd1;
                        end else if (cur.sub == 2'd1) begin
                           evt.kind = K_SOF_SAMP;
                           evt.value = {12'd0, data_byte[7:4]};
                           evt.value_second = {4'd0, data_byte[3:0]};
                           nxt.sub = 2'd2;
                        end else begin
                           evt.kind = K_SOF_QT;
                           nxt.sub = 2'd0;
                           nxt.comp_idx = cur.comp_idx + 8'd1;
                        end
                     end
                  end
                  PH_DRI: begin
                     if (c == 16'd2) begin
                        nxt.hold = data_byte;
                     end else if (c == 16'd3) begin
                        evt.valid = 1'b1;
                        evt.kind = K_DRI;
                        evt.value = word;
                     end
                  end
                  PH_DHT: begin
                     evt.valid = 1'b1;
                     evt.kind = K_DHT_BYTE;
                     evt.slot = c[7:0] - 8'd2;
                     evt.value = b16;
                  end
                  PH_SOS: begin
                     evt.value = b16;
                     if (c == 16'd2) begin
                        evt.valid = 1'b1;
                        evt.kind = K_SOS_NC;
                        nxt.comp_total = data_byte;
                        nxt.comp_idx = '0;
                        nxt.sub = '0;
                     end else if (cur.comp_idx < cur.comp_total) begin
                        evt.valid = 1'b1;
                        evt.slot = cur.comp_idx;
                        if (cur.sub == 2'd0) begin
                           evt.kind = K_SOS_CID;
                           nxt.sub = 2'd1;
                        end else begin
                           evt.kind = K_SOS_TBL;
                           evt.value = {12'd0, data_byte[7:4]};
                           evt.value_second = {4'd0, data_byte[3:0]};
                           nxt.sub = 2'd0;
                           nxt.comp_idx = cur.comp_idx + 8'd1;
                        end
                     end else if (cur.sub != 2'd3) begin
                        evt.valid = 1'b1;
                        nxt.sub = cur.sub + 2'd1;
                        case (cur.sub)
                           2'd0:    evt.kind = K_SOS_SS;
                           2'd1:    evt.kind = K_SOS_SE;
                           default: evt.kind = K_SOS_AH;
                        endcase
                     end
                  end
                  default: begin
                     evt.valid = 1'b0;
                  end
               endcase
            end
            if (c != 16'd0 && c_plus >= {1'b0, len_now}) begin
               nxt.phase = (cur.phase == PH_SOS) ? PH_ENTROPY : PH_SCAN;
               nxt.cnt   = '0;
               nxt.fill  = '0;
            end else begin
               nxt.cnt = c_plus[15:0];
            end
         end
         default: begin
            nxt.phase = PH_SCAN;
         end
      endcase
   end

endmodule

// ===== hw/rtl/jpeg_marker_segment_parser.sv =====
// Each accepted byte updates the parser state in the same cycle and its event, if any, is
// loaded into the output register, so one byte is taken every cycle; a new byte waits only
// while a held event is stalled. An event shows in the cycle after its byte. Entropy bytes
// after SOS come out two bytes late, and the last two bytes of a file never come out.
`timescale 1ns / 1ps
`include "jpeg_marker_segment_parser_macros.svh"

module jpeg_marker_segment_parser
   import jmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_kind,
   output logic [7:0]  rsp_slot,
   output logic [15:0] rsp_value,
   output logic [7:0]  rsp_value_second
);

   state_type state_ff, state_in, step_state;
   event_type step_evt;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [4:0]  kind_ff;
   logic [7:0]  slot_ff;
   logic [15:0] value_ff;
   logic [7:0]  second_ff;
   logic        accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   jmsp_step u_step (
      .cur       (state_ff),
      .data_byte (req_data_byte),
      .nxt       (step_state),
      .evt       (step_evt)
   );

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = req_last_byte ? state_type'('0) : step_state;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = step_evt.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_evt.valid) begin
         kind_ff   <= step_evt.kind;
         slot_ff   <= step_evt.slot;
         value_ff  <= step_evt.value;
         second_ff <= step_evt.value_second;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_value        = value_ff;
   assign rsp_value_second = second_ff;

   `JMSP_ASSERT_IMPL(a_stall_only_when_full, req_stall, rsp_valid_ff)
   `JMSP_ASSERT_NEXT(a_last_resets, accept && req_last_byte, state_ff.phase == PH_SCAN)
   `JMSP_ASSERT_IMPL(a_kind_range, rsp_valid_ff, kind_ff <= K_ENTROPY)
   `JMSP_ASSERT_NEXT(a_fill_bound, 1'b1, state_ff.fill != 2'd3)

endmodule
